// ----- sv/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Capacity, field widths, status codes and the control bundle that the
// queue drives into every cell of the row.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int STAT_W   = 2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef logic signed [DATA_W-1:0] entry_t;

  // Per-cycle command broadcast to the cells.
  typedef struct packed {
    logic ins;             // insert x into the row this cycle
    logic rem;             // shift the row toward the front this cycle
    logic smallest_first;  // placement order for inserts
  } cell_ctl_t;

endpackage

// ----- sv/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted row
// Holds one entry and its valid bit. On insert it keeps its entry, takes the
// new value, or takes its left neighbor's entry; on removal it takes its
// right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t   x,
  input  spq_pkg::entry_t   left_entry,
  input  logic              left_valid,
  input  logic              left_any,    // some cell nearer the front takes x
  input  spq_pkg::entry_t   right_entry,
  input  logic              right_valid,
  output spq_pkg::entry_t   entry,
  output logic              valid,
  output logic              any_out,
  output spq_pkg::entry_t   entry_nxt_o,
  output logic              valid_nxt_o
);
  import spq_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;
  logic   hit;

  // An empty slot always accepts; held entries follow the current order.
  assign hit = !valid_r ||
               (ctl.smallest_first ? (entry_r >= x) : (entry_r <= x));

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    if (ctl.ins) begin
      if (left_any) begin
        entry_nxt = left_entry;
        valid_nxt = left_valid;
      end else if (hit) begin
        entry_nxt = x;
        valid_nxt = 1'b1;
      end
    end else if (ctl.rem) begin
      entry_nxt = right_entry;
      valid_nxt = right_valid;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign entry       = entry_r;
  assign valid       = valid_r;
  assign any_out     = left_any || hit;
  assign entry_nxt_o = entry_nxt;
  assign valid_nxt_o = valid_nxt;

endmodule

// ----- sv/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue on a row of sorting cells
// Every cell updates in the same cycle; results are registered on acceptance.
// Throughput: one transaction per cycle unless a held result stalls the input.
// Reset clears the count, the cell valid bits, the result valid bit and the order
// bit (largest first); entry and result payloads are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: bit 0 is smallest_first.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_data,
  // Input transactions.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] value
  input  logic [0:0]  in_tuser,    // [0] action
  // Result transactions.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // [31:0] removed_value, [63:32] front_value,
                                   // [64] is_empty, [69:65] entry_count, rest 0
  output logic [1:0]  out_tuser    // [1:0] status
);
  import spq_pkg::*;

  // The queue is a row of cells, front at index 0. Each cell compares its
  // entry with the incoming value, and a prefix OR runs along the row so that
  // exactly the first matching cell takes the value while all cells behind it
  // take their left neighbor's entry. A removal shifts the whole row forward.
  // Because empty cells always match, an insert with no held match lands at
  // the tail. The row is never re-sorted when the order bit changes.

  logic             smallest_first_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             out_valid_r;
  logic [STAT_W-1:0] status_r;
  entry_t           removed_r, front_r;
  logic             empty_r;
  logic [CNT_W-1:0] out_count_r;

  logic             accept;
  logic             is_insert, is_remove;
  logic             full, empty;
  logic [STAT_W-1:0] status_nxt;
  cell_ctl_t        ctl;
  entry_t           x;

  entry_t           cell_entry [CAPACITY];
  logic             cell_valid [CAPACITY];
  logic             cell_any   [CAPACITY];
  entry_t           cell_enxt  [CAPACITY];
  logic             cell_vnxt  [CAPACITY];

  // Configuration writes are always taken; the user makes them only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smallest_first_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      smallest_first_r <= cfg_data[0];
    end
  end

  // The result register frees up when its transaction is taken, so a new
  // input is accepted in the same cycle as the old result leaves.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign x         = entry_t'(in_tdata);

  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign is_insert = accept && (in_tuser[0] == ACT_INSERT);
  assign is_remove = accept && (in_tuser[0] == ACT_REMOVE);

  assign ctl.ins            = is_insert && !full;
  assign ctl.rem            = is_remove && !empty;
  assign ctl.smallest_first = smallest_first_r;

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    if (is_insert) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (is_remove) begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // The row of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_v, right_v, left_a;

    if (i == 0) begin : g_head
      assign left_e = x;
      assign left_v = 1'b0;
      assign left_a = 1'b0;
    end else begin : g_body
      assign left_e = cell_entry[i-1];
      assign left_v = cell_valid[i-1];
      assign left_a = cell_any[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = x;
      assign right_v = 1'b0;
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
      assign right_v = cell_valid[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .x           (x),
      .left_entry  (left_e),
      .left_valid  (left_v),
      .left_any    (left_a),
      .right_entry (right_e),
      .right_valid (right_v),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i]),
      .any_out     (cell_any[i]),
      .entry_nxt_o (cell_enxt[i]),
      .valid_nxt_o (cell_vnxt[i])
    );
  end

  // Result stage: the front after the update comes from the head cell's
  // next value, the removed value from its current one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      removed_r   <= ctl.rem ? cell_entry[0] : '0;
      front_r     <= cell_vnxt[0] ? cell_enxt[0] : '0;
      empty_r     <= (count_nxt == '0);
      out_count_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {2'b00, out_count_r, empty_r, front_r, removed_r};

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[0] == (count_r != '0))
    else $error("head cell valid bit disagrees with the count");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (empty_r == (out_count_r == '0)))
    else $error("empty flag disagrees with reported count");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> (out_count_r == CNT_W'(CAPACITY)))
    else $error("insert dropped while queue not full");

endmodule
